/* src/mcn_pkg.sv */
// mcn_pkg: shared types and constants of the mesh cell normal unit
// used by every module of the block; depends on nothing

package mcn_pkg;

    // vertex store size and the widths that follow from it
    localparam int MAX_POINTS = 8;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // datapath widths
    localparam int COORD_W = 24;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int VEC_W   = PROD_W + 2;
    localparam int NRM_W   = 16;
    localparam int SUM_W   = NRM_W + $clog2(MAX_POINTS);
    localparam int TYPE_W  = 3;

    // cell type codes
    localparam logic [TYPE_W-1:0] TYPE_TRI   = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_POLY4 = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_POLY5 = 3'd5;

    // one vertex, x in the lowest bits
    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [NRM_W-1:0] nrm_t;

endpackage

/* src/mcn_vstore.sv */
// mcn_vstore: vertex store of the current cell, one write and one read port
// depends on mcn_pkg

module mcn_vstore (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [mcn_pkg::IDX_W-1:0] wr_addr,
    input  mcn_pkg::point_t          wr_data,
    input  logic [mcn_pkg::IDX_W-1:0] rd_addr,
    output mcn_pkg::point_t          rd_data
);

    mcn_pkg::point_t mem [mcn_pkg::MAX_POINTS];
    mcn_pkg::point_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/mcn_cross.sv */
// mcn_cross: cross product of two triangle edges on one shared multiplier
// depends on mcn_pkg

module mcn_cross (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  mcn_pkg::point_t pa,
    input  mcn_pkg::point_t pb,
    input  mcn_pkg::point_t pc,
    output logic            done,
    output mcn_pkg::vec_t   cx,
    output mcn_pkg::vec_t   cy,
    output mcn_pkg::vec_t   cz
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_MUL  = 2'd1;
    localparam logic [1:0] C_DONE = 2'd2;

    logic [1:0] st_reg;
    logic [2:0] step_reg;
    logic signed [mcn_pkg::EDGE_W-1:0] ux_reg, uy_reg, uz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [mcn_pkg::PROD_W-1:0] prod_reg;
    mcn_pkg::vec_t n_reg [3];
    logic signed [mcn_pkg::EDGE_W-1:0] op_a, op_b;
    logic [2:0]    acc_step;
    mcn_pkg::vec_t prod_ext;

    // operand selection for each of the six products
    always_comb begin
        op_a = uy_reg;
        op_b = wz_reg;
        case (step_reg)
            3'd0: begin op_a = uy_reg; op_b = wz_reg; end
            3'd1: begin op_a = uz_reg; op_b = wy_reg; end
            3'd2: begin op_a = uz_reg; op_b = wx_reg; end
            3'd3: begin op_a = ux_reg; op_b = wz_reg; end
            3'd4: begin op_a = ux_reg; op_b = wy_reg; end
            3'd5: begin op_a = uy_reg; op_b = wx_reg; end
            default: begin op_a = uy_reg; op_b = wz_reg; end
        endcase
    end

    assign acc_step = step_reg - 3'd1;
    assign prod_ext = mcn_pkg::vec_t'(prod_reg);

    // edge setup, multiply, then accumulate one product behind
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= C_IDLE;
            step_reg <= '0;
        end else begin
            unique case (st_reg)
                C_IDLE: begin
                    if (start) begin
                        ux_reg   <= mcn_pkg::EDGE_W'(pb.x) - mcn_pkg::EDGE_W'(pa.x);
                        uy_reg   <= mcn_pkg::EDGE_W'(pb.y) - mcn_pkg::EDGE_W'(pa.y);
                        uz_reg   <= mcn_pkg::EDGE_W'(pb.z) - mcn_pkg::EDGE_W'(pa.z);
                        wx_reg   <= mcn_pkg::EDGE_W'(pc.x) - mcn_pkg::EDGE_W'(pa.x);
                        wy_reg   <= mcn_pkg::EDGE_W'(pc.y) - mcn_pkg::EDGE_W'(pa.y);
                        wz_reg   <= mcn_pkg::EDGE_W'(pc.z) - mcn_pkg::EDGE_W'(pa.z);
                        step_reg <= '0;
                        st_reg   <= C_MUL;
                    end
                end
                C_MUL: begin
                    if (step_reg < 3'd6) begin
                        prod_reg <= op_a * op_b;
                    end
                    if (step_reg != 3'd0) begin
                        if (acc_step[0] == 1'b0) begin
                            n_reg[acc_step[2:1]] <= prod_ext;
                        end else begin
                            n_reg[acc_step[2:1]] <= n_reg[acc_step[2:1]] - prod_ext;
                        end
                    end
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd6) begin
                        st_reg <= C_DONE;
                    end
                end
                C_DONE: begin
                    st_reg <= C_IDLE;
                end
                default: begin
                    st_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign done = (st_reg == C_DONE);
    assign cx   = n_reg[0];
    assign cy   = n_reg[1];
    assign cz   = n_reg[2];

endmodule

/* src/mcn_norm.sv */
// mcn_norm: vector normalization to q1.14 with a bit-serial square root and divider
// depends on mcn_pkg

module mcn_norm (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  mcn_pkg::vec_t vx,
    input  mcn_pkg::vec_t vy,
    input  mcn_pkg::vec_t vz,
    output logic          done,
    output mcn_pkg::nrm_t nx,
    output mcn_pkg::nrm_t ny,
    output mcn_pkg::nrm_t nz
);

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_SQRT  = 3'd3;
    localparam logic [2:0] N_DLOAD = 3'd4;
    localparam logic [2:0] N_DIV   = 3'd5;
    localparam logic [2:0] N_DONE  = 3'd6;

    localparam int MAG_W = mcn_pkg::VEC_W;
    localparam int DIV_W = 48;
    localparam int Q_W   = 15;

    logic [2:0]       st_reg;
    logic [MAG_W-1:0] mag_reg [3];
    logic             neg_reg [3];
    logic [59:0]      prod_reg;
    logic [63:0]      acc_reg, s_reg, r_reg, bit_reg;
    logic [DIV_W-1:0] rem_reg, den_reg;
    logic [Q_W-1:0]   q_reg;
    logic [3:0]       cnt_reg;
    logic [1:0]       comp_reg;
    mcn_pkg::nrm_t    o_reg [3];

    logic [MAG_W-1:0] mx;
    logic [63:0]      trial;
    logic [Q_W-1:0]   q_next;
    logic             rem_ge;
    mcn_pkg::nrm_t    q_signed;

    // largest magnitude
    always_comb begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx) mx = mag_reg[1];
        if (mag_reg[2] > mx) mx = mag_reg[2];
    end

    assign trial    = r_reg + bit_reg;
    assign rem_ge   = (rem_reg >= den_reg);
    assign q_next   = {q_reg[Q_W-2:0], rem_ge};
    assign q_signed = neg_reg[comp_reg] ? -mcn_pkg::nrm_t'({1'b0, q_next})
                                        :  mcn_pkg::nrm_t'({1'b0, q_next});

    // sequencer: scale, sum of squares, square root, three divisions; a zero vector gives a zero result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= N_IDLE;
        end else begin
            unique case (st_reg)
                N_IDLE: begin
                    if (start) begin
                        mag_reg[0] <= vx[MAG_W-1] ? MAG_W'(-vx) : MAG_W'(vx);
                        mag_reg[1] <= vy[MAG_W-1] ? MAG_W'(-vy) : MAG_W'(vy);
                        mag_reg[2] <= vz[MAG_W-1] ? MAG_W'(-vz) : MAG_W'(vz);
                        neg_reg[0] <= vx[MAG_W-1];
                        neg_reg[1] <= vy[MAG_W-1];
                        neg_reg[2] <= vz[MAG_W-1];
                        if (vx == '0 && vy == '0 && vz == '0) begin
                            o_reg[0] <= '0;
                            o_reg[1] <= '0;
                            o_reg[2] <= '0;
                            st_reg   <= N_DONE;
                        end else begin
                            st_reg <= N_SHIFT;
                        end
                    end
                end
                // one bit a cycle until the largest lies in [2^29, 2^30)
                N_SHIFT: begin
                    if (mx[MAG_W-1:30] != '0) begin
                        mag_reg[0] <= mag_reg[0] >> 1;
                        mag_reg[1] <= mag_reg[1] >> 1;
                        mag_reg[2] <= mag_reg[2] >> 1;
                    end else if (!mx[29]) begin
                        mag_reg[0] <= mag_reg[0] << 1;
                        mag_reg[1] <= mag_reg[1] << 1;
                        mag_reg[2] <= mag_reg[2] << 1;
                    end else begin
                        cnt_reg <= '0;
                        acc_reg <= '0;
                        st_reg  <= N_SQ;
                    end
                end
                // square each component, accumulate one behind
                N_SQ: begin
                    if (cnt_reg < 4'd3) begin
                        prod_reg <= mag_reg[cnt_reg[1:0]][29:0] * mag_reg[cnt_reg[1:0]][29:0];
                    end
                    if (cnt_reg != 4'd0) begin
                        acc_reg <= acc_reg + 64'(prod_reg);
                    end
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd3) begin
                        s_reg   <= acc_reg + 64'(prod_reg);
                        r_reg   <= '0;
                        bit_reg <= 64'd1 << 62;
                        st_reg  <= N_SQRT;
                    end
                end
                // integer square root, one result bit a cycle
                N_SQRT: begin
                    if (bit_reg == '0) begin
                        comp_reg <= '0;
                        st_reg   <= N_DLOAD;
                    end else begin
                        if (s_reg >= trial) begin
                            s_reg <= s_reg - trial;
                            r_reg <= (r_reg >> 1) + bit_reg;
                        end else begin
                            r_reg <= r_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                // numerator 2*m*16384 + r, divisor 2*r aligned to the top quotient bit
                N_DLOAD: begin
                    rem_reg <= DIV_W'({mag_reg[comp_reg][29:0], 15'd0}) + DIV_W'(r_reg[31:0]);
                    den_reg <= DIV_W'({r_reg[32:0], 15'd0});
                    q_reg   <= '0;
                    cnt_reg <= '0;
                    st_reg  <= N_DIV;
                end
                // restoring division, one quotient bit a cycle
                N_DIV: begin
                    if (rem_ge) begin
                        rem_reg <= rem_reg - den_reg;
                    end
                    q_reg   <= q_next;
                    den_reg <= den_reg >> 1;
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(Q_W - 1)) begin
                        o_reg[comp_reg] <= q_signed;
                        if (comp_reg == 2'd2) begin
                            st_reg <= N_DONE;
                        end else begin
                            comp_reg <= comp_reg + 2'd1;
                            st_reg   <= N_DLOAD;
                        end
                    end
                end
                N_DONE: begin
                    st_reg <= N_IDLE;
                end
                default: begin
                    st_reg <= N_IDLE;
                end
            endcase
        end
    end

    assign done = (st_reg == N_DONE);
    assign nx   = o_reg[0];
    assign ny   = o_reg[1];
    assign nz   = o_reg[2];

endmodule

/* src/mesh_cell_normal_unit_top.sv */
// mesh_cell_normal_unit_top: one unit normal per mesh cell from a vertex stream
// depends on mcn_pkg, mcn_vstore, mcn_cross, mcn_norm
//
//  channel | dir | tdata                          | tuser            | tlast
//  s_      | in  | vertex_x, vertex_y, vertex_z   | cell_type        | last_vertex
//  m_      | out | normal_x, normal_y, normal_z   | vertex_overflow  | -
//
// a vertex without tlast leaves the block ready again at once
// a last vertex starts the cell walk for types 4 and 5 and for type 3 with three or more
// vertices (a zero normal otherwise): per triangle three store reads, a cross product
// on the shared multiplier and a normalization (scaling, squares, root, three divides)
// types 4 and 5 walk each consecutive vertex triple and add one more normalization
// synchronous active-low reset; no clearing pass, the store needs none
// a waiting result does not block new vertices; only the next cell's result waits for it

module mesh_cell_normal_unit_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // vertex_x [23:0], vertex_y [47:24], vertex_z [71:48]
    input  logic [2:0]  s_tuser,   // cell_type [2:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // normal_x [15:0], normal_y [31:16], normal_z [47:32]
    output logic        m_tuser    // vertex_overflow [0]
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RDA    = 4'd1;
    localparam logic [3:0] ST_RDB    = 4'd2;
    localparam logic [3:0] ST_RDC    = 4'd3;
    localparam logic [3:0] ST_CAP    = 4'd4;
    localparam logic [3:0] ST_XSTART = 4'd5;
    localparam logic [3:0] ST_XWAIT  = 4'd6;
    localparam logic [3:0] ST_NSTART = 4'd7;
    localparam logic [3:0] ST_NWAIT  = 4'd8;
    localparam logic [3:0] ST_FSTART = 4'd9;
    localparam logic [3:0] ST_FWAIT  = 4'd10;
    localparam logic [3:0] ST_OUT    = 4'd11;

    localparam int IW = mcn_pkg::IDX_W;
    localparam int CW = mcn_pkg::CNT_W;
    localparam int SW = mcn_pkg::SUM_W;

    logic [3:0]    st_reg;
    logic [CW-1:0] cnt_reg, ncell_reg, tri_reg;
    logic          ovf_reg, covf_reg, poly_reg;
    logic [IW-1:0] ia_reg, ib_reg, ic_reg;
    mcn_pkg::point_t pa_reg, pb_reg, pc_reg;
    logic signed [SW-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    mcn_pkg::nrm_t res_x_reg, res_y_reg, res_z_reg;
    logic          m_valid_reg, m_user_reg;
    logic [47:0]   m_data_reg;

    logic          s_acc, wr_ok, out_load;
    logic [CW-1:0] cnt_inc;
    logic [IW-1:0] rd_addr;
    mcn_pkg::point_t rd_data;
    logic          x_done, n_done;
    mcn_pkg::vec_t cx, cy, cz, vx, vy, vz;
    mcn_pkg::nrm_t nx, ny, nz;

    // next index around the cell
    function automatic logic [IW-1:0] inc_wrap(input logic [IW-1:0] x,
                                               input logic [CW-1:0] n);
        logic [CW-1:0] t;
        t = CW'(x) + CW'(1);
        return (t == n) ? '0 : t[IW-1:0];
    endfunction

    assign s_tready = (st_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign wr_ok    = (cnt_reg < CW'(mcn_pkg::MAX_POINTS));
    assign cnt_inc  = wr_ok ? cnt_reg + CW'(1) : cnt_reg;
    assign out_load = (st_reg == ST_OUT) && (!m_valid_reg || m_tready);

    // store read address per read state
    always_comb begin
        case (st_reg)
            ST_RDB:  rd_addr = ib_reg;
            ST_RDC:  rd_addr = ic_reg;
            default: rd_addr = ia_reg;
        endcase
    end

    mcn_vstore u_vstore (
        .aclk    (aclk),
        .wr_en   (s_acc && wr_ok),
        .wr_addr (cnt_reg[IW-1:0]),
        .wr_data (mcn_pkg::point_t'(s_tdata)),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mcn_cross u_cross (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (st_reg == ST_XSTART),
        .pa      (pa_reg),
        .pb      (pb_reg),
        .pc      (pc_reg),
        .done    (x_done),
        .cx      (cx),
        .cy      (cy),
        .cz      (cz)
    );

    // normalization input: cross product, or the polygon sum at the end
    assign vx = (st_reg == ST_FSTART) ? mcn_pkg::vec_t'(sum_x_reg) : cx;
    assign vy = (st_reg == ST_FSTART) ? mcn_pkg::vec_t'(sum_y_reg) : cy;
    assign vz = (st_reg == ST_FSTART) ? mcn_pkg::vec_t'(sum_z_reg) : cz;

    mcn_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   ((st_reg == ST_NSTART) || (st_reg == ST_FSTART)),
        .vx      (vx),
        .vy      (vy),
        .vz      (vz),
        .done    (n_done),
        .nx      (nx),
        .ny      (ny),
        .nz      (nz)
    );

    // cell sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_IDLE;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            unique case (st_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        if (!s_tlast) begin
                            cnt_reg <= cnt_inc;
                            ovf_reg <= ovf_reg | !wr_ok;
                        end else begin
                            cnt_reg   <= '0;
                            ovf_reg   <= 1'b0;
                            ncell_reg <= cnt_inc;
                            covf_reg  <= ovf_reg | !wr_ok;
                            tri_reg   <= '0;
                            sum_x_reg <= '0;
                            sum_y_reg <= '0;
                            sum_z_reg <= '0;
                            res_x_reg <= '0;
                            res_y_reg <= '0;
                            res_z_reg <= '0;
                            ia_reg    <= '0;
                            ib_reg    <= (cnt_inc == CW'(1)) ? '0 : IW'(1);
                            ic_reg    <= (cnt_inc > CW'(2)) ? IW'(2) : '0;
                            poly_reg  <= 1'b0;
                            st_reg    <= ST_OUT;
                            case (s_tuser) inside
                                mcn_pkg::TYPE_TRI: begin
                                    if (cnt_inc >= CW'(3)) begin
                                        st_reg <= ST_RDA;
                                    end
                                end
                                mcn_pkg::TYPE_POLY4, mcn_pkg::TYPE_POLY5: begin
                                    poly_reg <= 1'b1;
                                    st_reg   <= ST_RDA;
                                end
                                default: begin
                                    st_reg <= ST_OUT;
                                end
                            endcase
                        end
                    end
                end
                ST_RDA: st_reg <= ST_RDB;
                ST_RDB: begin
                    pa_reg <= rd_data;
                    st_reg <= ST_RDC;
                end
                ST_RDC: begin
                    pb_reg <= rd_data;
                    st_reg <= ST_CAP;
                end
                ST_CAP: begin
                    pc_reg <= rd_data;
                    st_reg <= ST_XSTART;
                end
                ST_XSTART: st_reg <= ST_XWAIT;
                ST_XWAIT: begin
                    if (x_done) st_reg <= ST_NSTART;
                end
                ST_NSTART: st_reg <= ST_NWAIT;
                // triangle normal ready: finish, or add it and walk on
                ST_NWAIT: begin
                    if (n_done) begin
                        if (!poly_reg) begin
                            res_x_reg <= nx;
                            res_y_reg <= ny;
                            res_z_reg <= nz;
                            st_reg    <= ST_OUT;
                        end else begin
                            sum_x_reg <= sum_x_reg + SW'(nx);
                            sum_y_reg <= sum_y_reg + SW'(ny);
                            sum_z_reg <= sum_z_reg + SW'(nz);
                            tri_reg   <= tri_reg + CW'(1);
                            ia_reg    <= inc_wrap(ia_reg, ncell_reg);
                            ib_reg    <= inc_wrap(ib_reg, ncell_reg);
                            ic_reg    <= inc_wrap(ic_reg, ncell_reg);
                            if (tri_reg + CW'(1) == ncell_reg) begin
                                st_reg <= ST_FSTART;
                            end else begin
                                st_reg <= ST_RDA;
                            end
                        end
                    end
                end
                ST_FSTART: st_reg <= ST_FWAIT;
                ST_FWAIT: begin
                    if (n_done) begin
                        res_x_reg <= nx;
                        res_y_reg <= ny;
                        res_z_reg <= nz;
                        st_reg    <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {res_z_reg, res_y_reg, res_x_reg};
            m_user_reg <= covf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // vertex count never passes the store size
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(mcn_pkg::MAX_POINTS))
        else $error("vertex count beyond store size");

    // a plain vertex keeps the block ready
    a_plain_vertex: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !s_tlast) |=> s_tready)
        else $error("plain vertex stalled the input");

    // a cell end leaves the idle state and clears the vertex count and overflow flag
    a_cell_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tlast) |=> (!s_tready && cnt_reg == '0 && !ovf_reg))
        else $error("cell end did not start the walk");

    // result components stay within the unit range
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) >= -16'sd16384 &&
                      $signed(m_tdata[15:0]) <= 16'sd16384 &&
                      $signed(m_tdata[31:16]) >= -16'sd16384 &&
                      $signed(m_tdata[31:16]) <= 16'sd16384 &&
                      $signed(m_tdata[47:32]) >= -16'sd16384 &&
                      $signed(m_tdata[47:32]) <= 16'sd16384))
        else $error("normal component out of range");

endmodule

/* dv/mesh_cell_normal_unit_top_test.sv */
// mesh_cell_normal_unit_top_test: self-checking bench for the mesh cell normal unit
// depends on mcn_pkg and mesh_cell_normal_unit_top; drives vertex items, checks normals
`timescale 1ns / 1ps

module mesh_cell_normal_unit_top_test;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int N_DIRECTED   = 23;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;

    mesh_cell_normal_unit_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // one vertex item
    typedef struct {
        logic [mcn_pkg::TYPE_W-1:0]         ctype;
        logic signed [mcn_pkg::COORD_W-1:0] vx;
        logic signed [mcn_pkg::COORD_W-1:0] vy;
        logic signed [mcn_pkg::COORD_W-1:0] vz;
        logic                               last;
    } vertex_item_t;

    // one cell normal
    typedef struct {
        mcn_pkg::nrm_t nx;
        mcn_pkg::nrm_t ny;
        mcn_pkg::nrm_t nz;
        logic          ovf;
    } cell_normal_t;

    // directed row: item plus an optional typed-in result
    typedef struct {
        vertex_item_t item;
        logic         has_known;
        cell_normal_t known;
    } directed_row_t;

    cell_normal_t   pending_normals[$];
    directed_row_t  directed_rows[N_DIRECTED];
    longint         cell_x[mcn_pkg::MAX_POINTS];
    longint         cell_y[mcn_pkg::MAX_POINTS];
    longint         cell_z[mcn_pkg::MAX_POINTS];
    int             cell_count;
    bit             cell_dropped;
    int             cycle_count;
    int             error_count;
    bit             quiet_phase;

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // integer square root, floor
    function automatic longint unsigned floor_sqrt(longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // scale to Q1.14 unit length, round half up on the magnitude
    function automatic void unit_scale(input longint v[3], output longint o[3]);
        longint unsigned m[3];
        longint unsigned mx, s, r, q;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            for (int i = 0; i < 3; i++) o[i] = 0;
            return;
        end
        while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        r = floor_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = (2 * m[i] * 16384 + r) / (2 * r);
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
    endfunction

    // unit normal of stored vertices a, b, c
    function automatic void triangle_normal(input int a, input int b, input int c,
                                            output longint o[3]);
        longint ux, uy, uz, wx, wy, wz;
        longint n[3];
        ux = cell_x[b] - cell_x[a];
        uy = cell_y[b] - cell_y[a];
        uz = cell_z[b] - cell_z[a];
        wx = cell_x[c] - cell_x[a];
        wy = cell_y[c] - cell_y[a];
        wz = cell_z[c] - cell_z[a];
        n[0] = uy * wz - uz * wy;
        n[1] = uz * wx - ux * wz;
        n[2] = ux * wy - uy * wx;
        unit_scale(n, o);
    endfunction

    // predictor: returns 1 and the normal when the item ends a cell
    function automatic bit predict_normal(input vertex_item_t it, output cell_normal_t res);
        longint nrm[3];
        longint sum[3];
        longint t[3];
        nrm = '{0, 0, 0};
        res = '{default: '0};
        if (cell_count < mcn_pkg::MAX_POINTS) begin
            cell_x[cell_count] = it.vx;
            cell_y[cell_count] = it.vy;
            cell_z[cell_count] = it.vz;
            cell_count++;
        end else begin
            cell_dropped = 1'b1;
        end
        if (!it.last) return 0;
        if (it.ctype == mcn_pkg::TYPE_TRI) begin
            if (cell_count >= 3) triangle_normal(0, 1, 2, nrm);
        end else if (it.ctype == mcn_pkg::TYPE_POLY4 || it.ctype == mcn_pkg::TYPE_POLY5) begin
            sum = '{0, 0, 0};
            for (int i = 0; i < cell_count; i++) begin
                triangle_normal(i, (i + 1) % cell_count, (i + 2) % cell_count, t);
                for (int k = 0; k < 3; k++) sum[k] += t[k];
            end
            unit_scale(sum, nrm);
        end
        res.nx  = mcn_pkg::nrm_t'(nrm[0]);
        res.ny  = mcn_pkg::nrm_t'(nrm[1]);
        res.nz  = mcn_pkg::nrm_t'(nrm[2]);
        res.ovf = cell_dropped;
        cell_count   = 0;
        cell_dropped = 1'b0;
        return 1;
    endfunction

    // send one vertex item, at random outside the quiet phase with an idle burst before it
    task automatic send_vertex(input vertex_item_t it);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.vz, it.vy, it.vx};
        s_tuser  <= it.ctype;
        s_tlast  <= it.last;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic vertex_item_t make_vertex(logic [2:0] t, int x, int y, int z, bit l);
        vertex_item_t it;
        it.ctype = t;
        it.vx = x[mcn_pkg::COORD_W-1:0];
        it.vy = y[mcn_pkg::COORD_W-1:0];
        it.vz = z[mcn_pkg::COORD_W-1:0];
        it.last = l;
        return it;
    endfunction

    function automatic int random_coord(bit wide);
        if (wide || $urandom_range(0, 7) == 0) return int'($urandom);
        return int'($urandom_range(0, 8191)) - 4096;
    endfunction

    // check each result against the oldest expectation
    always @(posedge aclk) begin
        cell_normal_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_normals.size() == 0) begin
                $error("result with nothing expected: %h %b", m_tdata, m_tuser);
                error_count++;
            end else begin
                want = pending_normals.pop_front();
                if (mcn_pkg::nrm_t'(m_tdata[15:0]) !== want.nx) begin
                    $error("normal_x expected %0d got %0d", want.nx, $signed(m_tdata[15:0]));
                    error_count++;
                end
                if (mcn_pkg::nrm_t'(m_tdata[31:16]) !== want.ny) begin
                    $error("normal_y expected %0d got %0d", want.ny, $signed(m_tdata[31:16]));
                    error_count++;
                end
                if (mcn_pkg::nrm_t'(m_tdata[47:32]) !== want.nz) begin
                    $error("normal_z expected %0d got %0d", want.nz, $signed(m_tdata[47:32]));
                    error_count++;
                end
                if (m_tuser !== want.ovf) begin
                    $error("vertex_overflow expected %0b got %0b", want.ovf, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // result side backpressure
    always @(posedge aclk) begin
        if (!aresetn || quiet_phase) begin
            m_tready <= 1'b1;
        end else if (m_tready && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
            m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("mesh_cell_normal_unit_top_test: FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin
        vertex_item_t it;
        cell_normal_t res;
        int n_items, nv;
        logic [2:0] t;
        bit wide;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        cell_count = 0;
        cell_dropped = 1'b0;
        cycle_count = 0;
        error_count = 0;
        quiet_phase = 1'b0;

        // directed rows: unused types, axis triangle, short cells, extremes, overflow
        directed_rows[0]  = '{make_vertex(0, 256, 0, 0, 1), 1, '{0, 0, 0, 0}};
        directed_rows[1]  = '{make_vertex(7, 1, 2, 3, 1), 1, '{0, 0, 0, 0}};
        directed_rows[2]  = '{make_vertex(3, 0, 0, 0, 0), 0, '{default: '0}};
        directed_rows[3]  = '{make_vertex(3, 256, 0, 0, 0), 0, '{default: '0}};
        directed_rows[4]  = '{make_vertex(3, 0, 256, 0, 1), 1, '{0, 0, 16384, 0}};
        directed_rows[5]  = '{make_vertex(3, 5, 5, 5, 0), 0, '{default: '0}};
        directed_rows[6]  = '{make_vertex(3, 9, 9, 9, 1), 1, '{0, 0, 0, 0}};
        directed_rows[7]  = '{make_vertex(4, 3, 3, 3, 1), 1, '{0, 0, 0, 0}};
        directed_rows[8]  = '{make_vertex(5, -8388608, 8388607, -8388608, 0), 0, '{default: '0}};
        directed_rows[9]  = '{make_vertex(5, 8388607, -8388608, 8388607, 0), 0, '{default: '0}};
        directed_rows[10] = '{make_vertex(5, 8388607, 8388607, -8388608, 0), 0, '{default: '0}};
        directed_rows[11] = '{make_vertex(5, -8388608, -8388608, 8388607, 1), 0, '{default: '0}};
        directed_rows[12] = '{make_vertex(3, -8388608, -8388608, -8388608, 0), 0, '{default: '0}};
        directed_rows[13] = '{make_vertex(3, 8388607, -8388608, -8388608, 0), 0, '{default: '0}};
        directed_rows[14] = '{make_vertex(3, -8388608, 8388607, -8388608, 1), 0, '{default: '0}};
        for (int i = 15; i < 23; i++)
            directed_rows[i] = '{make_vertex(4, (i % 3) * 1000, (i % 5) * 700, i * 11,
                                             i == 22), 0, '{default: '0}};
        // nine vertices for the overflow row set above: add one more in the loop
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (i == 22) begin
                it = make_vertex(4, -300, 1200, 77, 0);
                if (predict_normal(it, res)) pending_normals.push_back(res);
                send_vertex(it);
            end
            if (predict_normal(directed_rows[i].item, res))
                pending_normals.push_back(directed_rows[i].has_known ? directed_rows[i].known
                                                                     : res);
            send_vertex(directed_rows[i].item);
        end

        // random cells, mostly well formed, some noise
        n_items = 0;
        while (n_items < 1850) begin
            if (n_items > 1600) quiet_phase = 1'b1;
            nv = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
            t = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(3, 5))
                                           : 3'($urandom_range(0, 7));
            wide = $urandom_range(0, 3) == 0;
            for (int v = 0; v < nv; v++) begin
                it = make_vertex(3'($urandom_range(0, 7)), random_coord(wide),
                                 random_coord(wide), random_coord(wide), v == nv - 1);
                if (it.last) it.ctype = t;
                if (predict_normal(it, res)) pending_normals.push_back(res);
                send_vertex(it);
                n_items++;
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // drain
        while (pending_normals.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (error_count == 0)
            $display("mesh_cell_normal_unit_top_test: PASS");
        else
            $display("mesh_cell_normal_unit_top_test: FAIL");
        $finish;
    end

endmodule
